FILE: sv/pft_pkg.sv
`timescale 1ns / 1ps

package pft_pkg;

  localparam int PFT_CAPACITY = 64;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_FIRST  = 3'd1;
  localparam logic [2:0] FN_NEXT   = 3'd2;
  localparam logic [2:0] FN_LAST   = 3'd3;
  localparam logic [2:0] FN_PREV   = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] cost;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_cost;
    logic [31:0] out_value;
  } out_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic        valid;
    logic        le;
    logic        rm;
    logic [31:0] cost;
    logic [31:0] value;
  } nb_t;

  typedef struct packed {
    nb_t  nb;
    logic rej;
    logic eqh;
    logic sel;
  } cell_o_t;

  typedef struct packed {
    logic        look;
    logic        upd_eq;
    logic        upd_repl;
    logic        upd_ins;
    logic        shift;
    logic        clear;
    logic [31:0] cost;
    logic [31:0] value;
  } ccmd_t;

  typedef struct packed {
    logic any_rm;
    logic reject;
    logic eq;
  } flags_t;

endpackage

FILE: sv/pft_cell.sv
`timescale 1ns / 1ps

module pft_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pft_pkg::ccmd_t     cmd,
  input  logic [IDX_W-1:0]   tgt,
  input  pft_pkg::nb_t       left,
  input  pft_pkg::nb_t       right,
  output pft_pkg::cell_o_t   cell_o
);
  import pft_pkg::*;

  logic        valid_r;
  logic        le_r;
  logic        rm_r;
  logic        shen_r;
  logic        geq_r;
  logic        eqc_r;
  logic        sel_r;
  logic [31:0] cost_r;
  logic [31:0] value_r;
  logic        cost_le;
  logic        pred;
  logic        head;

  assign cost_le = cost_r <= cmd.cost;
  // last entry not above the new cost, and first slot at or after it
  assign pred    = le_r & ~right.le;
  assign head    = ~le_r & left.le;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rm_r    <= 1'b0;
      shen_r  <= 1'b0;
    end else begin
      if (cmd.look) begin
        rm_r <= valid_r & ~cost_le & (value_r <= cmd.value);
      end
      if (cmd.clear) begin
        valid_r <= 1'b0;
      end
      if (cmd.upd_eq) begin
        shen_r <= ~le_r;
      end
      if (cmd.upd_repl) begin
        shen_r <= ~le_r & ~head;
        if (head) begin
          rm_r <= 1'b0;
        end
      end
      if (cmd.upd_ins && !le_r) begin
        valid_r <= head ? 1'b1 : left.valid;
      end
      if (cmd.shift && shen_r) begin
        valid_r <= right.valid;
        rm_r    <= right.rm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      le_r  <= valid_r & cost_le;
      geq_r <= value_r >= cmd.value;
      eqc_r <= cost_r == cmd.cost;
      sel_r <= tgt == IDX_W'(IDX);
    end
    if (cmd.upd_eq && pred) begin
      value_r <= cmd.value;
    end
    if (cmd.upd_repl && head) begin
      cost_r  <= cmd.cost;
      value_r <= cmd.value;
    end
    if (cmd.upd_ins && !le_r) begin
      cost_r  <= head ? cmd.cost : left.cost;
      value_r <= head ? cmd.value : left.value;
    end
    // close the gap: take the right neighbor's entry
    if (cmd.shift && shen_r) begin
      cost_r  <= right.cost;
      value_r <= right.value;
    end
  end

  assign cell_o.nb.valid = valid_r;
  assign cell_o.nb.le    = le_r;
  assign cell_o.nb.rm    = rm_r;
  assign cell_o.nb.cost  = cost_r;
  assign cell_o.nb.value = value_r;
  assign cell_o.rej      = pred & geq_r;
  assign cell_o.eqh      = pred & eqc_r;
  assign cell_o.sel      = sel_r;

endmodule

FILE: sv/pft_ctrl.sv
`timescale 1ns / 1ps

module pft_ctrl #(
  parameter int CAPACITY = pft_pkg::PFT_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pft_pkg::in_t      in_item,
  output logic              out_strobe,
  output pft_pkg::out_t     out_item,
  input  pft_pkg::flags_t   flags,
  input  logic [31:0]       rd_cost,
  input  logic [31:0]       rd_value,
  output pft_pkg::ccmd_t    ccmd,
  output logic [IDX_W-1:0]  tgt
);
  import pft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOK   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_SHIFT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  in_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] iter_pos_r, iter_pos_nxt;
  logic             iter_valid_r, iter_valid_nxt;
  logic [IDX_W-1:0] p_pos_r, p_pos_nxt;
  logic             p_valid_r, p_valid_nxt;
  logic             p_found_r, p_found_nxt;
  out_t             out_r, out_nxt;
  logic             ostb_r, ostb_nxt;

  logic [IDX_W-1:0] pp_pos;
  logic             pp_valid;
  logic             pp_found;
  logic             is_ins;
  logic             ins_ok;
  logic             full;
  logic             need_shift;
  logic             accept;
  logic [CNT_W-1:0] pos_ext;

  assign is_ins     = cmd_r.func == FN_INSERT;
  assign ins_ok     = is_ins & ~flags.reject;
  assign full       = (count_r == CNT_W'(CAPACITY)) & ~flags.any_rm;
  assign need_shift = ins_ok & flags.any_rm;
  assign busy       = (state_r == S_LOOK) || (state_r == S_COMMIT && need_shift) ||
                      (state_r == S_SHIFT && flags.any_rm);
  assign accept     = start & ~busy;
  assign pos_ext    = CNT_W'(iter_pos_r);

  // iterator move, worked out ahead of the commit
  always_comb begin
    pp_pos   = iter_pos_r;
    pp_valid = iter_valid_r;
    pp_found = 1'b0;
    case (cmd_r.func)
      FN_FIRST: begin
        if (count_r != '0) begin
          pp_pos   = '0;
          pp_valid = 1'b1;
          pp_found = 1'b1;
        end else begin
          pp_valid = 1'b0;
        end
      end
      FN_NEXT: begin
        if (iter_valid_r) begin
          if (pos_ext + CNT_W'(1) < count_r) begin
            pp_pos   = iter_pos_r + IDX_W'(1);
            pp_found = 1'b1;
          end else begin
            pp_valid = 1'b0;
          end
        end
      end
      FN_LAST: begin
        if (count_r != '0) begin
          pp_pos   = IDX_W'(count_r - CNT_W'(1));
          pp_valid = 1'b1;
          pp_found = 1'b1;
        end else begin
          pp_valid = 1'b0;
        end
      end
      FN_PREV: begin
        if (iter_valid_r) begin
          if (iter_pos_r != '0 && pos_ext < count_r) begin
            pp_pos   = iter_pos_r - IDX_W'(1);
            pp_found = 1'b1;
          end else begin
            pp_valid = 1'b0;
          end
        end
      end
      default: begin
        pp_found = 1'b0;
      end
    endcase
  end

  assign tgt = pp_pos;

  always_comb begin
    ccmd.look     = state_r == S_LOOK;
    ccmd.upd_eq   = (state_r == S_COMMIT) & ins_ok & flags.eq;
    ccmd.upd_repl = (state_r == S_COMMIT) & ins_ok & ~flags.eq & flags.any_rm;
    ccmd.upd_ins  = (state_r == S_COMMIT) & ins_ok & ~flags.eq & ~flags.any_rm & ~full;
    ccmd.shift    = (state_r == S_SHIFT) & flags.any_rm;
    ccmd.clear    = (state_r == S_COMMIT) & (cmd_r.func == FN_CLEAR);
    ccmd.cost     = cmd_r.cost;
    ccmd.value    = cmd_r.value;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    iter_pos_nxt   = iter_pos_r;
    iter_valid_nxt = iter_valid_r;
    p_pos_nxt      = p_pos_r;
    p_valid_nxt    = p_valid_r;
    p_found_nxt    = p_found_r;
    out_nxt        = out_r;
    ostb_nxt       = 1'b0;
    if (accept) begin
      cmd_nxt = in_item;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        p_pos_nxt   = pp_pos;
        p_valid_nxt = pp_valid;
        p_found_nxt = pp_found;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        ostb_nxt          = 1'b1;
        out_nxt.out_cost  = '0;
        out_nxt.out_value = '0;
        out_nxt.status    = ST_MISS;
        case (cmd_r.func)
          FN_INSERT: begin
            iter_valid_nxt = 1'b0;
            if (flags.reject) begin
              out_nxt.status = ST_MISS;
            end else if (flags.eq) begin
              out_nxt.status = ST_DONE;
            end else if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              out_nxt.status = ST_DONE;
              if (!flags.any_rm) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          FN_FIRST, FN_NEXT, FN_LAST, FN_PREV: begin
            iter_pos_nxt   = p_pos_r;
            iter_valid_nxt = p_valid_r;
            if (p_found_r) begin
              out_nxt.status    = ST_DONE;
              out_nxt.out_cost  = rd_cost;
              out_nxt.out_value = rd_value;
            end
          end
          FN_CLEAR: begin
            count_nxt      = '0;
            iter_valid_nxt = 1'b0;
            out_nxt.status = ST_DONE;
          end
          default: begin
            out_nxt.status = ST_MISS;
          end
        endcase
        if (need_shift) begin
          state_nxt = S_SHIFT;
        end else if (accept) begin
          state_nxt = S_LOOK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        // drop one dominated entry per cycle
        if (flags.any_rm) begin
          count_nxt = count_r - CNT_W'(1);
        end else if (accept) begin
          state_nxt = S_LOOK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      iter_pos_r   <= '0;
      iter_valid_r <= 1'b0;
      ostb_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      iter_pos_r   <= iter_pos_nxt;
      iter_valid_r <= iter_valid_nxt;
      ostb_r       <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    p_pos_r   <= p_pos_nxt;
    p_valid_r <= p_valid_nxt;
    p_found_r <= p_found_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_item   = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_iter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    iter_valid_r |-> (pos_ext < count_r))
    else $error("iterator points past the last entry");

  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_COMMIT))
    else $error("result beat without a commit");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ST_FULL) |-> $past(count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_shift_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (cmd_r.func == FN_INSERT))
    else $error("compaction outside an insert");

endmodule

FILE: sv/pareto_front_table_unit.sv
`timescale 1ns / 1ps
// A result beat follows the accepting edge through the look and commit states and the
// output register, is shown for one cycle, and is taken at the edge that ends that cycle.
// A new item can be accepted while the previous one commits, unless that one removes
// dominated entries (also when it raises the value of an existing cost): busy then holds
// while they are shifted out of the row of cells, one entry per cycle.
// Reset clears the entry count and the iterator; entry contents are not cleared.
// The receiver cannot stall: each result beat is taken as it appears.

module pareto_front_table_unit #(
  parameter int CAPACITY = pft_pkg::PFT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pft_pkg::in_t  in_item,
  output logic          out_strobe,
  output pft_pkg::out_t out_item
);
  import pft_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam nb_t LEFT_EDGE  = '{valid: 1'b1, le: 1'b1, rm: 1'b0, cost: '0, value: '0};
  localparam nb_t RIGHT_EDGE = '{valid: 1'b0, le: 1'b0, rm: 1'b0, cost: '0, value: '0};

  ccmd_t            ccmd;
  logic [IDX_W-1:0] tgt;
  flags_t           flags;
  logic [31:0]      rd_cost;
  logic [31:0]      rd_value;
  cell_o_t          co  [CAPACITY];
  nb_t              lnb [CAPACITY];
  nb_t              rnb [CAPACITY];

  pft_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .flags      (flags),
    .rd_cost    (rd_cost),
    .rd_value   (rd_value),
    .ccmd       (ccmd),
    .tgt        (tgt)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lnb[g] = LEFT_EDGE;
    end else begin : g_mid_l
      assign lnb[g] = co[g-1].nb;
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rnb[g] = RIGHT_EDGE;
    end else begin : g_mid_r
      assign rnb[g] = co[g+1].nb;
    end

    pft_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (ccmd),
      .tgt    (tgt),
      .left   (lnb[g]),
      .right  (rnb[g]),
      .cell_o (co[g])
    );
  end

  // OR the per-cell flags and the one selected entry
  always_comb begin
    flags    = '0;
    rd_cost  = '0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      flags.any_rm = flags.any_rm | co[i].nb.rm;
      flags.reject = flags.reject | co[i].rej;
      flags.eq     = flags.eq | co[i].eqh;
      rd_cost      = rd_cost | (co[i].nb.cost & {32{co[i].sel}});
      rd_value     = rd_value | (co[i].nb.value & {32{co[i].sel}});
    end
  end

endmodule

FILE: tb/pareto_front_table_unit_tb.sv
`timescale 1ns / 1ps

module pareto_front_table_unit_tb;
  import pft_pkg::*;

  // func codes the block does not implement; they must answer a miss
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic out_strobe;
  in_t  in_item;
  out_t out_item;

  pareto_front_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // shadow copy of the front, kept in cost order
  logic [31:0] front_cost[$];
  logic [31:0] front_value[$];
  int          cursor_pos;
  bit          cursor_ok;

  out_t expected_results[$];
  out_t oldest_result;
  int   mismatch_count;
  int   burst_left;
  int   cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [1:0] front_insert(input logic [31:0] c, input logic [31:0] v);
    int n;
    int pos;
    int j;
    n = front_cost.size();
    pos = 0;
    cursor_ok = 1'b0;
    while (pos < n && front_cost[pos] <= c) pos++;
    if (pos > 0 && front_value[pos-1] >= v) return ST_MISS;
    if (pos > 0 && front_cost[pos-1] == c) begin
      front_value[pos-1] = v;
      // drop followers that the raised value now dominates
      while (pos < front_cost.size() && front_value[pos] <= v) begin
        front_cost.delete(pos);
        front_value.delete(pos);
      end
      return ST_DONE;
    end
    j = pos;
    while (j < n && front_value[j] <= v) j++;
    if (n - (j - pos) + 1 > PFT_CAPACITY) return ST_FULL;
    repeat (j - pos) begin
      front_cost.delete(pos);
      front_value.delete(pos);
    end
    front_cost.insert(pos, c);
    front_value.insert(pos, v);
    return ST_DONE;
  endfunction

  function automatic out_t front_step(input in_t item);
    out_t res;
    bit   found;
    res = '0;
    res.status = ST_MISS;
    found = 1'b0;
    case (item.func)
      FN_INSERT: res.status = front_insert(item.cost, item.value);
      FN_FIRST: begin
        if (front_cost.size() > 0) begin
          cursor_pos = 0;
          cursor_ok = 1'b1;
          found = 1'b1;
        end else begin
          cursor_ok = 1'b0;
        end
      end
      FN_NEXT: begin
        if (cursor_ok) begin
          if (cursor_pos + 1 < front_cost.size()) begin
            cursor_pos++;
            found = 1'b1;
          end else begin
            cursor_ok = 1'b0;
          end
        end
      end
      FN_LAST: begin
        if (front_cost.size() > 0) begin
          cursor_pos = front_cost.size() - 1;
          cursor_ok = 1'b1;
          found = 1'b1;
        end else begin
          cursor_ok = 1'b0;
        end
      end
      FN_PREV: begin
        if (cursor_ok) begin
          if (cursor_pos > 0 && cursor_pos < front_cost.size()) begin
            cursor_pos--;
            found = 1'b1;
          end else begin
            cursor_ok = 1'b0;
          end
        end
      end
      FN_CLEAR: begin
        front_cost.delete();
        front_value.delete();
        cursor_ok = 1'b0;
        res.status = ST_DONE;
      end
      default: ;
    endcase
    if (found) begin
      res.status    = ST_DONE;
      res.out_cost  = front_cost[cursor_pos];
      res.out_value = front_value[cursor_pos];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH at %0t: %s: want %0h got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, 32'(out_item.status));
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_item.status !== oldest_result.status)
          report_mismatch("status", 32'(oldest_result.status), 32'(out_item.status));
        if (out_item.out_cost !== oldest_result.out_cost)
          report_mismatch("out_cost", oldest_result.out_cost, out_item.out_cost);
        if (out_item.out_value !== oldest_result.out_value)
          report_mismatch("out_value", oldest_result.out_value, out_item.out_value);
      end
    end
  end

  // Hold the beat until the block takes it, then idle between bursts.
  task automatic send_op(input logic [2:0] fn, input logic [31:0] c, input logic [31:0] v);
    in_t item;
    int  gap;
    item.func  = fn;
    item.cost  = c;
    item.value = v;
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_results.push_back(front_step(item));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_empty_table;
    send_op(FN_FIRST, 32'd0, 32'd0);
    send_op(FN_LAST, 32'd0, 32'd0);
    send_op(FN_NEXT, 32'd0, 32'd0);
    send_op(FN_PREV, 32'd0, 32'd0);
    send_op(FN_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_SPARE_B, 32'h5555_AAAA, 32'hAAAA_5555);
    send_op(FN_CLEAR, 32'd0, 32'd0);
  endtask

  task automatic test_insert_rules;
    send_op(FN_INSERT, 32'd100, 32'd50);
    send_op(FN_INSERT, 32'd100, 32'd50);            // equal value: rejected
    send_op(FN_INSERT, 32'd100, 32'd60);            // raise existing cost
    send_op(FN_INSERT, 32'd50, 32'd60);             // cheaper, removes the old one
    send_op(FN_INSERT, 32'd200, 32'd70);
    send_op(FN_INSERT, 32'd300, 32'd80);
    send_op(FN_INSERT, 32'd150, 32'd75);            // displaces the 200 entry
    send_op(FN_INSERT, 32'd0, 32'd0);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_op(FN_INSERT, 32'd0, 32'hFFFF_FFFF);       // wipes everything behind it
  endtask

  task automatic test_iteration;
    send_op(FN_CLEAR, 32'd0, 32'd0);
    send_op(FN_INSERT, 32'd10, 32'd1);
    send_op(FN_INSERT, 32'd20, 32'd2);
    send_op(FN_FIRST, 32'd0, 32'd0);
    send_op(FN_NEXT, 32'd0, 32'd0);
    send_op(FN_NEXT, 32'd0, 32'd0);                 // runs off the end
    send_op(FN_PREV, 32'd0, 32'd0);                 // iterator already dead
    send_op(FN_LAST, 32'd0, 32'd0);
    send_op(FN_PREV, 32'd0, 32'd0);
    send_op(FN_PREV, 32'd0, 32'd0);                 // steps before the start
    send_op(FN_FIRST, 32'd0, 32'd0);
    send_op(FN_INSERT, 32'd20, 32'd1);              // rejected, still kills the iterator
    send_op(FN_NEXT, 32'd0, 32'd0);
  endtask

  task automatic test_full_table;
    logic [31:0] fill_cost[PFT_CAPACITY];
    logic [31:0] fill_value[PFT_CAPACITY];
    bit          descend;
    int          i;
    descend = 1'($urandom_range(0, 1));
    fill_cost[0]  = $urandom_range(0, 1000);
    fill_value[0] = $urandom_range(0, 1000);
    for (i = 1; i < PFT_CAPACITY; i++) begin
      fill_cost[i]  = fill_cost[i-1] + $urandom_range(2, 1000);
      fill_value[i] = fill_value[i-1] + $urandom_range(2, 1000);
    end
    send_op(FN_CLEAR, 32'd0, 32'd0);
    for (i = 0; i < PFT_CAPACITY; i++) begin
      if (descend)
        send_op(FN_INSERT, fill_cost[PFT_CAPACITY-1-i], fill_value[PFT_CAPACITY-1-i]);
      else
        send_op(FN_INSERT, fill_cost[i], fill_value[i]);
    end
    send_op(FN_INSERT, fill_cost[10] + 1, fill_value[10] + 1);   // no room
    send_op(FN_INSERT, fill_cost[20], fill_value[20] + 1);       // raise needs no room
    send_op(FN_FIRST, 32'd0, 32'd0);
    repeat (PFT_CAPACITY) send_op(FN_NEXT, $urandom, $urandom);
    send_op(FN_LAST, 32'd0, 32'd0);
    repeat (4) send_op(FN_PREV, $urandom, $urandom);
    send_op(FN_INSERT, fill_cost[30] + 1, fill_value[31]);       // removal makes room
    send_op(FN_INSERT, fill_cost[40] + 1, fill_value[40] + 1);   // full again
  endtask

  task automatic test_random_mix;
    int          sent;
    int          pick;
    int          steps;
    logic [31:0] c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // small costs with values rising roughly with cost grow a deep front
        c = $urandom_range(0, 600);
        send_op(FN_INSERT, c, c * 8 + $urandom_range(0, 60));
        sent++;
      end else if (pick < 63) begin
        send_op(FN_INSERT, $urandom, $urandom);
        sent++;
      end else if (pick < 83) begin
        steps = $urandom_range(1, 10);
        send_op($urandom_range(0, 1) ? FN_FIRST : FN_LAST, $urandom, $urandom);
        repeat (steps) send_op($urandom_range(0, 1) ? FN_NEXT : FN_PREV, $urandom, $urandom);
        sent += steps + 1;
      end else if (pick < 97) begin
        send_op(3'($urandom_range(FN_FIRST, FN_SPARE_B)), $urandom, $urandom);
        sent++;
      end else begin
        send_op(FN_CLEAR, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    mismatch_count = 0;
    burst_left     = 0;
    cursor_pos     = 0;
    cursor_ok      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_insert_rules();
    test_iteration();
    test_full_table();
    test_random_mix();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/pft_pkg.sv
sv/pft_cell.sv
sv/pft_ctrl.sv
sv/pareto_front_table_unit.sv
tb/pareto_front_table_unit_tb.sv
